// ----- src/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Screen geometry, cell layout, character codes, register indexes, the
// sequencer states and the result bundle passed from the sequencer to the top.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS_COUNT = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS_COUNT;

	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS_COUNT);
	localparam int ADDR_W     = 11;
	localparam int CHAR_W     = 8;
	localparam int COLOUR_W   = 8;
	localparam int NIBBLE_W   = 4;
	localparam int CELL_W     = CHAR_W + COLOUR_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = NIBBLE_W;

	localparam logic [CHAR_W-1:0]   NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0]   NUL_CODE     = 8'd0;
	localparam logic [CHAR_W-1:0]   SPACE_CODE   = 8'd32;
	localparam logic [COLOUR_W-1:0] RESET_COLOUR = 8'h0A;
	localparam logic [NIBBLE_W-1:0] FG_RESET     = 4'd10;
	localparam logic [NIBBLE_W-1:0] BG_RESET     = 4'd0;

	localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'b1;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCROLL,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              valid;
		logic              rd_hit;
		logic [ADDR_W-1:0] offset;
	} result_t;

endpackage

// ----- src/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencer of the text console writer
// Holds the cursor and the colour registers, runs the clearing pass after
// reset, handles put and read transactions and steps the scroll copy through
// the single RAM port pair, one cell per cycle.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  operation,
	input  logic [CHAR_W-1:0]     char_code,
	input  logic [ADDR_W-1:0]     cell_index,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  mem_we,
	output logic [ADDR_W-1:0]     mem_waddr,
	output logic [CELL_W-1:0]     mem_wdata,
	output logic [ADDR_W-1:0]     mem_raddr,
	input  logic [CELL_W-1:0]     mem_rdata,
	output result_t               res
);

	state_t               state_q, state_d;
	logic [COL_W-1:0]     col_q, col_d;
	logic [ROW_W-1:0]     row_q, row_d;
	logic [ADDR_W-1:0]    addr_q, addr_d;
	logic                 rd_hit_q, rd_hit_d;
	logic [NIBBLE_W-1:0]  fg_q, bg_q;
	logic                 vld_s1, blank_s1;
	logic [ADDR_W-1:0]    addr_s1;

	logic [COLOUR_W-1:0]  colour;
	logic [ADDR_W-1:0]    cur_off;
	logic [COL_W:0]       col_inc;
	logic [ROW_W:0]       row_inc;
	logic                 col_wrap, row_ovf, next_row, accept;

	assign colour   = {bg_q, fg_q};
	assign cur_off  = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(COLUMNS)) + ADDR_W'(col_q);
	assign col_inc  = {1'b0, col_q} + (COL_W+1)'(1);
	assign row_inc  = {1'b0, row_q} + (ROW_W+1)'(1);
	assign col_wrap = (col_inc == (COL_W+1)'(COLUMNS));
	assign row_ovf  = (row_inc == (ROW_W+1)'(ROWS_COUNT));
	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;

	assign res.valid  = (state_q == ST_FINISH);
	assign res.rd_hit = rd_hit_q;
	assign res.offset = cur_off;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			col_q    <= '0;
			row_q    <= '0;
			addr_q   <= '0;
			rd_hit_q <= 1'b0;
			vld_s1   <= 1'b0;
			fg_q     <= FG_RESET;
			bg_q     <= BG_RESET;
		end else begin
			state_q  <= state_d;
			col_q    <= col_d;
			row_q    <= row_d;
			addr_q   <= addr_d;
			rd_hit_q <= rd_hit_d;
			vld_s1   <= (state_q == ST_SCROLL);
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FOREGROUND: fg_q <= cfg_data;
					CFG_BACKGROUND: bg_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// scroll pipeline: the write follows the read of the row below in the next cycle
	always_ff @(posedge clk) begin
		addr_s1  <= addr_q;
		blank_s1 <= (addr_q >= ADDR_W'(CELL_COUNT - COLUMNS));
	end

	always_comb begin
		state_d   = state_q;
		col_d     = col_q;
		row_d     = row_q;
		addr_d    = addr_q;
		rd_hit_d  = rd_hit_q;
		mem_we    = 1'b0;
		mem_waddr = cur_off;
		mem_wdata = {char_code, colour};
		mem_raddr = cell_index;
		next_row  = 1'b0;

		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q;
				mem_wdata = {SPACE_CODE, RESET_COLOUR};
				if (addr_q == ADDR_W'(CELL_COUNT - 1)) begin
					addr_d  = '0;
					state_d = ST_IDLE;
				end else begin
					addr_d = addr_q + ADDR_W'(1);
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (operation == OP_READ) begin
						rd_hit_d = (cell_index < ADDR_W'(CELL_COUNT));
					end else begin
						rd_hit_d = 1'b0;
						if (char_code == NEWLINE_CODE) begin
							col_d    = '0;
							next_row = 1'b1;
						end else if (char_code != NUL_CODE) begin
							mem_we = 1'b1;
							if (col_wrap) begin
								col_d    = '0;
								next_row = 1'b1;
							end else begin
								col_d = col_inc[COL_W-1:0];
							end
						end
						if (next_row) begin
							row_d = row_inc[ROW_W-1:0];
						end
					end
					if (next_row && row_ovf) begin
						// keep the cursor on the last row and scroll
						row_d   = ROW_W'(ROWS_COUNT - 1);
						addr_d  = '0;
						state_d = ST_SCROLL;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SCROLL: begin
				mem_raddr = ADDR_W'({1'b0, addr_q} + (ADDR_W+1)'(COLUMNS));
				if (addr_q == ADDR_W'(CELL_COUNT - 1)) begin
					addr_d  = '0;
					state_d = ST_DRAIN;
				end else begin
					addr_d = addr_q + ADDR_W'(1);
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// copy a cell up one row, or blank it on the bottom row
		if (vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = addr_s1;
			mem_wdata = blank_s1 ? {SPACE_CODE, colour} : mem_rdata;
		end
	end

endmodule

// ----- src/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// Keeps a cursor and a screen of character/colour cells, puts characters
// with wrap and scroll, and reads cells back. Results leave through a
// registered strobe.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  input    | start & !busy          | operation, char_code, cell_index
//  result   | done (one cycle)       | cursor_offset, cell_char, cell_colour
//  config   | cfg_we                 | cfg_index, cfg_data
//
//  A read, a NUL, a newline or a character without scroll passes through
//  ST_FINISH to done. A put that scrolls passes through ST_SCROLL, ST_DRAIN
//  and ST_FINISH; the scroll moves one cell per cycle through the screen RAM's
//  one write port. A clearing pass after reset fills all CELL_COUNT (2000) cells
//  with blank cells; busy stays high during it. Configuration writes are taken
//  at any time. The receiver cannot stall: done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  operation,
	input  logic [CHAR_W-1:0]     char_code,
	input  logic [ADDR_W-1:0]     cell_index,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [ADDR_W-1:0]     cursor_offset,
	output logic [CHAR_W-1:0]     cell_char,
	output logic [COLOUR_W-1:0]   cell_colour
);

	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
	logic [CELL_W-1:0]     mem_wdata, mem_rdata;
	result_t               res;
	logic                  done_q;
	logic [ADDR_W-1:0]     offset_q;
	logic [CHAR_W-1:0]     char_q;
	logic [COLOUR_W-1:0]   colour_q;

	tcw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.char_code  (char_code),
		.cell_index (cell_index),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.res        (res)
	);

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.valid;
		end
	end

	// hold the result payload; puts and out-of-range reads report a zero cell
	always_ff @(posedge clk) begin
		if (res.valid) begin
			offset_q <= res.offset;
			if (res.rd_hit) begin
				char_q   <= mem_rdata[CELL_W-1 -: CHAR_W];
				colour_q <= mem_rdata[COLOUR_W-1:0];
			end else begin
				char_q   <= '0;
				colour_q <= '0;
			end
		end
	end

	assign done          = done_q;
	assign cursor_offset = offset_q;
	assign cell_char     = char_q;
	assign cell_colour   = colour_q;

endmodule
